[sv/hbs_pkg.sv]
// Shared types, constants and helper functions of the heightmap sampler.
// Used by every module in this folder; depends on nothing else.
package hbs_pkg;

    localparam int GRID_DIM  = 64;
    localparam int MAX_CELLS = 63;
    localparam int CELL_LIM  = (MAX_CELLS < GRID_DIM - 1) ? MAX_CELLS : GRID_DIM - 1;
    localparam int CELL_W    = 6;
    localparam int ADDR_W    = 2 * CELL_W;
    localparam int DATA_W    = 32;
    localparam int SP_W      = 31;
    localparam int FRAC_W    = 16;
    localparam int Q_W       = CELL_W + FRAC_W;
    localparam int REM_W     = SP_W + CELL_W;
    localparam int LOCAL_W   = 34;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH   = 3'd0,
        CFG_GRID_HEIGHT  = 3'd1,
        CFG_GRID_SPACING = 3'd2,
        CFG_OFFSET_X     = 3'd3,
        CFG_OFFSET_Z     = 3'd4,
        CFG_ACTOR_X      = 3'd5,
        CFG_ACTOR_Y      = 3'd6,
        CFG_ACTOR_Z      = 3'd7
    } cfg_idx_t;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [CELL_W-1:0] grid_width;
        logic [CELL_W-1:0] grid_height;
        logic [SP_W-1:0]   grid_spacing;
        logic [SP_W-1:0]   offset_x;
        logic [SP_W-1:0]   offset_z;
        logic [DATA_W-1:0] actor_x;
        logic [DATA_W-1:0] actor_y;
        logic [DATA_W-1:0] actor_z;
    } cfg_t;

    // Sideband that rides along with every beat down the pipeline
    typedef struct packed {
        logic              func;
        logic [CELL_W-1:0] row;
        logic [CELL_W-1:0] column;
        logic [DATA_W-1:0] value;
        logic              outside;
    } item_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             q;
    } div_t;

    // Clamp a cell count to the range in use
    function automatic logic [CELL_W-1:0] cells_in_use(input logic [CELL_W-1:0] n);
        logic [CELL_W-1:0] r;
        r = n;
        if (r == '0)
            r = CELL_W'(1);
        if (r > CELL_W'(CELL_LIM))
            r = CELL_W'(CELL_LIM);
        return r;
    endfunction

    // Zero spacing acts as one
    function automatic logic [SP_W-1:0] spacing_eff(input logic [SP_W-1:0] sp);
        return (sp == '0) ? SP_W'(1) : sp;
    endfunction

    // One restoring step: compare, subtract, shift
    function automatic div_t div_step(input logic [REM_W-1:0] rem,
                                      input logic [REM_W-2:0] dvs);
        div_t r;
        logic [REM_W-1:0] diff;
        r.q  = (rem >= {1'b0, dvs});
        diff = r.q ? (rem - {1'b0, dvs}) : rem;
        r.rem = {diff[REM_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

[sv/hbs_ram.sv]
// One-write, one-read height store with registered read data.
// Depends on hbs_pkg for widths.
module hbs_ram
    import hbs_pkg::*;
(
    input  logic              clk,
    input  logic              re,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [GRID_DIM*GRID_DIM];
    logic [DATA_W-1:0] rdata_reg;

    // Write and read ports
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/hbs_front.sv]
// Front stages: local coordinates, grid limits, then the outside test.
// Depends on hbs_pkg.
module hbs_front
    import hbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic              func,
    input  logic [CELL_W-1:0] row,
    input  logic [CELL_W-1:0] column,
    input  logic [DATA_W-1:0] height_value,
    input  logic [DATA_W-1:0] pos_x,
    input  logic [DATA_W-1:0] pos_z,
    input  cfg_t              cfg,
    output logic              out_vld,
    output item_t             out_item,
    output logic [REM_W-1:0]  out_rx,
    output logic [REM_W-1:0]  out_rz
);

    logic               s1_vld_reg, s1_vld_next;
    item_t              s1_item_reg, s1_item_next;
    logic [LOCAL_W-1:0] s1_lx_reg, s1_lx_next;
    logic [LOCAL_W-1:0] s1_lz_reg, s1_lz_next;
    logic [REM_W-1:0]   s1_wl_reg, s1_wl_next;
    logic [REM_W-1:0]   s1_hl_reg, s1_hl_next;
    logic               s2_vld_reg;
    item_t              s2_item_reg, s2_item_next;
    logic [REM_W-1:0]   s2_rx_reg, s2_rx_next;
    logic [REM_W-1:0]   s2_rz_reg, s2_rz_next;
    logic [SP_W-1:0]    sp;
    logic               out_x, out_z;

    assign sp = spacing_eff(cfg.grid_spacing);

    // Stage 1: pos - origin + half extent, and cells * spacing
    always_comb
    begin
        s1_vld_next         = in_vld;
        s1_item_next.func   = func;
        s1_item_next.row    = row;
        s1_item_next.column = column;
        s1_item_next.value  = height_value;
        s1_item_next.outside = 1'b0;
        s1_lx_next = {{2{pos_x[DATA_W-1]}}, pos_x}
                   - {{2{cfg.actor_x[DATA_W-1]}}, cfg.actor_x}
                   + {3'b000, cfg.offset_x};
        s1_lz_next = {{2{pos_z[DATA_W-1]}}, pos_z}
                   - {{2{cfg.actor_z[DATA_W-1]}}, cfg.actor_z}
                   + {3'b000, cfg.offset_z};
        s1_wl_next = REM_W'(cells_in_use(cfg.grid_width)) * REM_W'(sp);
        s1_hl_next = REM_W'(cells_in_use(cfg.grid_height)) * REM_W'(sp);
    end

    // Stage 2: outside test, seed the divider remainders
    always_comb
    begin
        out_x = s1_lx_reg[LOCAL_W-1]
             || ({{(REM_W-LOCAL_W+1){1'b0}}, s1_lx_reg[LOCAL_W-2:0]} > s1_wl_reg);
        out_z = s1_lz_reg[LOCAL_W-1]
             || ({{(REM_W-LOCAL_W+1){1'b0}}, s1_lz_reg[LOCAL_W-2:0]} > s1_hl_reg);
        s2_item_next         = s1_item_reg;
        s2_item_next.outside = out_x || out_z;
        s2_rx_next = {{(REM_W-LOCAL_W+1){1'b0}}, s1_lx_reg[LOCAL_W-2:0]};
        s2_rz_next = {{(REM_W-LOCAL_W+1){1'b0}}, s1_lz_reg[LOCAL_W-2:0]};
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= s1_item_next;
            s1_lx_reg   <= s1_lx_next;
            s1_lz_reg   <= s1_lz_next;
            s1_wl_reg   <= s1_wl_next;
            s1_hl_reg   <= s1_hl_next;
            s2_item_reg <= s2_item_next;
            s2_rx_reg   <= s2_rx_next;
            s2_rz_reg   <= s2_rz_next;
        end
    end

    assign out_vld  = s2_vld_reg;
    assign out_item = s2_item_reg;
    assign out_rx   = s2_rx_reg;
    assign out_rz   = s2_rz_reg;

endmodule

[sv/hbs_div.sv]
// Pipelined restoring divider, one quotient bit per stage, x and z lanes.
// Yields floor(local * 2^16 / spacing) as 6 integer and 16 fraction bits.
// Depends on hbs_pkg.
module hbs_div
    import hbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [SP_W-1:0]   sp,
    input  logic              in_vld,
    input  item_t             in_item,
    input  logic [REM_W-1:0]  in_rx,
    input  logic [REM_W-1:0]  in_rz,
    output logic              out_vld,
    output item_t             out_item,
    output logic [Q_W-1:0]    qx,
    output logic [Q_W-1:0]    qz
);

    logic [REM_W-2:0] dvs;
    logic             vld_reg  [Q_W];
    item_t            item_reg [Q_W];
    logic [REM_W-1:0] rx_reg   [Q_W];
    logic [REM_W-1:0] rz_reg   [Q_W];
    logic [Q_W-1:0]   qx_reg   [Q_W];
    logic [Q_W-1:0]   qz_reg   [Q_W];

    // Divisor aligned with the top integer bit
    assign dvs = {sp, {CELL_W-1{1'b0}}};

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic             v_in;
        item_t            it_in;
        logic [REM_W-1:0] rx_in, rz_in;
        logic [Q_W-1:0]   qx_in, qz_in;
        div_t             sx, sz;

        if (k == 0)
        begin : g_first
            assign v_in  = in_vld;
            assign it_in = in_item;
            assign rx_in = in_rx;
            assign rz_in = in_rz;
            assign qx_in = '0;
            assign qz_in = '0;
        end
        else
        begin : g_next
            assign v_in  = vld_reg[k-1];
            assign it_in = item_reg[k-1];
            assign rx_in = rx_reg[k-1];
            assign rz_in = rz_reg[k-1];
            assign qx_in = qx_reg[k-1];
            assign qz_in = qz_reg[k-1];
        end

        assign sx = div_step(rx_in, dvs);
        assign sz = div_step(rz_in, dvs);

        // Advance valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= v_in;
        end

        // Advance remainder and shift in one quotient bit
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[k] <= it_in;
                rx_reg[k]   <= sx.rem;
                rz_reg[k]   <= sz.rem;
                qx_reg[k]   <= {qx_in[Q_W-2:0], sx.q};
                qz_reg[k]   <= {qz_in[Q_W-2:0], sz.q};
            end
        end
    end

    assign out_vld  = vld_reg[Q_W-1];
    assign out_item = item_reg[Q_W-1];
    assign qx       = qx_reg[Q_W-1];
    assign qz       = qz_reg[Q_W-1];

endmodule

[sv/hbs_lerp.sv]
// Bilinear blend of four corner heights, base height add and saturation.
// Five register stages ending in the output register. Depends on hbs_pkg.
module hbs_lerp
    import hbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic              in_outside,
    input  logic [FRAC_W-1:0] fx,
    input  logic [FRAC_W-1:0] fz,
    input  logic [DATA_W-1:0] h00,
    input  logic [DATA_W-1:0] h10,
    input  logic [DATA_W-1:0] h01,
    input  logic [DATA_W-1:0] h11,
    input  logic [DATA_W-1:0] actor_y,
    output logic              out_vld,
    output logic [DATA_W-1:0] height,
    output logic              outside
);

    localparam int PROD_W = DATA_W + FRAC_W + 2;
    localparam int SUM_W  = PROD_W + 1;

    logic                     p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg, p5_vld_reg;
    logic                     p1_out_reg, p2_out_reg, p3_out_reg, p4_out_reg, p5_out_reg;
    logic [FRAC_W-1:0]        p1_fz_reg, p2_fz_reg;
    logic signed [PROD_W-1:0] p1_a0_reg, p1_b0_reg, p1_a1_reg, p1_b1_reg;
    logic signed [PROD_W-1:0] p1_a0_next, p1_b0_next, p1_a1_next, p1_b1_next;
    logic [DATA_W-1:0]        p2_hx0_reg, p2_hx1_reg, p2_hx0_next, p2_hx1_next;
    logic signed [PROD_W-1:0] p3_c0_reg, p3_c1_reg, p3_c0_next, p3_c1_next;
    logic [DATA_W-1:0]        p4_v_reg, p4_v_next;
    logic [DATA_W-1:0]        p5_h_reg, p5_h_next;
    logic [FRAC_W:0]          wfx, wfz;
    logic signed [SUM_W-1:0]  sum0, sum1, sum2;
    logic [DATA_W:0]          res;

    // Weights 65536 - f
    assign wfx = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, fx};
    assign wfz = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, p2_fz_reg};

    // P1: four corner products
    always_comb
    begin
        p1_a0_next = $signed(h00) * $signed({1'b0, wfx});
        p1_b0_next = $signed(h10) * $signed({2'b00, fx});
        p1_a1_next = $signed(h01) * $signed({1'b0, wfx});
        p1_b1_next = $signed(h11) * $signed({2'b00, fx});
    end

    // P2: sum and floor along x
    always_comb
    begin
        sum0 = SUM_W'(p1_a0_reg) + SUM_W'(p1_b0_reg);
        sum1 = SUM_W'(p1_a1_reg) + SUM_W'(p1_b1_reg);
        p2_hx0_next = sum0[DATA_W+FRAC_W-1:FRAC_W];
        p2_hx1_next = sum1[DATA_W+FRAC_W-1:FRAC_W];
    end

    // P3: products along z
    always_comb
    begin
        p3_c0_next = $signed(p2_hx0_reg) * $signed({1'b0, wfz});
        p3_c1_next = $signed(p2_hx1_reg) * $signed({2'b00, p2_fz_reg});
    end

    // P4: sum and floor along z
    always_comb
    begin
        sum2 = SUM_W'(p3_c0_reg) + SUM_W'(p3_c1_reg);
        p4_v_next = sum2[DATA_W+FRAC_W-1:FRAC_W];
    end

    // P5: add base height, saturate, or pass base height when outside
    always_comb
    begin
        res = {actor_y[DATA_W-1], actor_y} + {p4_v_reg[DATA_W-1], p4_v_reg};
        if (p4_out_reg)
            p5_h_next = actor_y;
        else if (res[DATA_W] != res[DATA_W-1])
            p5_h_next = res[DATA_W] ? {1'b1, {DATA_W-1{1'b0}}} : {1'b0, {DATA_W-1{1'b1}}};
        else
            p5_h_next = res[DATA_W-1:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_vld_reg <= in_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_out_reg <= in_outside;
            p1_fz_reg  <= fz;
            p1_a0_reg  <= p1_a0_next;
            p1_b0_reg  <= p1_b0_next;
            p1_a1_reg  <= p1_a1_next;
            p1_b1_reg  <= p1_b1_next;
            p2_out_reg <= p1_out_reg;
            p2_fz_reg  <= p1_fz_reg;
            p2_hx0_reg <= p2_hx0_next;
            p2_hx1_reg <= p2_hx1_next;
            p3_out_reg <= p2_out_reg;
            p3_c0_reg  <= p3_c0_next;
            p3_c1_reg  <= p3_c1_next;
            p4_out_reg <= p3_out_reg;
            p4_v_reg   <= p4_v_next;
            p5_out_reg <= p4_out_reg;
            p5_h_reg   <= p5_h_next;
        end
    end

    assign out_vld = p5_vld_reg;
    assign height  = p5_h_reg;
    assign outside = p5_out_reg;

endmodule

[sv/heightmap_bilinear_sampler_top.sv]
// Top level of the heightmap sampler: config registers, pipeline, height store.
// Depends on hbs_pkg, hbs_front, hbs_div, hbs_ram and hbs_lerp.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  in      | in_valid / in_ready   | func row column height_value pos_x pos_z
//  out     | out_valid / out_ready | height outside (one beat per query)
//  cfg     | cfg_valid / cfg_ready | cfg_index cfg_data
//
// One beat enters per cycle while the output is not held; a query's result passes
// through 30 register stages: 2 front stages, 22 divider stages, the store read
// and 5 blend stages.
// Writes travel the same pipeline and update the store at the read stage.
// Reset clears valid bits and loads config defaults; the store holds garbage until written.
// A held output stalls the whole pipeline in place; cfg_ready is always high.
module heightmap_bilinear_sampler_top
    import hbs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [CELL_W-1:0]    row,
    input  logic [CELL_W-1:0]    column,
    input  logic [DATA_W-1:0]    height_value,
    input  logic [DATA_W-1:0]    pos_x,
    input  logic [DATA_W-1:0]    pos_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_W-1:0]    height,
    output logic                 outside,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    cfg_t              cfg_reg, cfg_next;
    logic              en;
    logic              fr_vld;
    item_t             fr_item;
    logic [REM_W-1:0]  fr_rx, fr_rz;
    logic              dv_vld;
    item_t             dv_item;
    logic [Q_W-1:0]    dv_qx, dv_qz;
    logic [CELL_W-1:0] w_cells, h_cells, x0, x1, z0, z1;
    logic [ADDR_W-1:0] ra00, ra10, ra01, ra11, waddr;
    logic              we;
    logic [DATA_W-1:0] h00, h10, h01, h11;
    logic              mem_vld_reg, mem_vld_next;
    logic              mem_out_reg;
    logic [FRAC_W-1:0] mem_fx_reg, mem_fz_reg;

    // Whole pipeline moves unless the output beat is held
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // Config register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GRID_WIDTH:   cfg_next.grid_width   = cfg_data[CELL_W-1:0];
                CFG_GRID_HEIGHT:  cfg_next.grid_height  = cfg_data[CELL_W-1:0];
                CFG_GRID_SPACING: cfg_next.grid_spacing = cfg_data[SP_W-1:0];
                CFG_OFFSET_X:     cfg_next.offset_x     = cfg_data[SP_W-1:0];
                CFG_OFFSET_Z:     cfg_next.offset_z     = cfg_data[SP_W-1:0];
                CFG_ACTOR_X:      cfg_next.actor_x      = cfg_data;
                CFG_ACTOR_Y:      cfg_next.actor_y      = cfg_data;
                CFG_ACTOR_Z:      cfg_next.actor_z      = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width   <= CELL_W'(63);
            cfg_reg.grid_height  <= CELL_W'(63);
            cfg_reg.grid_spacing <= SP_W'(65536);
            cfg_reg.offset_x     <= '0;
            cfg_reg.offset_z     <= '0;
            cfg_reg.actor_x      <= '0;
            cfg_reg.actor_y      <= '0;
            cfg_reg.actor_z      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hbs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (in_valid && in_ready),
        .func         (func),
        .row          (row),
        .column       (column),
        .height_value (height_value),
        .pos_x        (pos_x),
        .pos_z        (pos_z),
        .cfg          (cfg_reg),
        .out_vld      (fr_vld),
        .out_item     (fr_item),
        .out_rx       (fr_rx),
        .out_rz       (fr_rz)
    );

    hbs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .sp       (spacing_eff(cfg_reg.grid_spacing)),
        .in_vld   (fr_vld),
        .in_item  (fr_item),
        .in_rx    (fr_rx),
        .in_rz    (fr_rz),
        .out_vld  (dv_vld),
        .out_item (dv_item),
        .qx       (dv_qx),
        .qz       (dv_qz)
    );

    // Corner addresses; clamp upper neighbors to the grid edge
    always_comb
    begin
        w_cells = cells_in_use(cfg_reg.grid_width);
        h_cells = cells_in_use(cfg_reg.grid_height);
        x0 = dv_qx[Q_W-1:FRAC_W];
        z0 = dv_qz[Q_W-1:FRAC_W];
        x1 = (x0 >= w_cells) ? w_cells : x0 + CELL_W'(1);
        z1 = (z0 >= h_cells) ? h_cells : z0 + CELL_W'(1);
        ra00  = {z0, x0};
        ra10  = {z0, x1};
        ra01  = {z1, x0};
        ra11  = {z1, x1};
        waddr = {dv_item.row, dv_item.column};
        we    = en && dv_vld && (dv_item.func == FUNC_WRITE);
        mem_vld_next = dv_vld && (dv_item.func == FUNC_QUERY);
    end

    // Four copies of the store, each with one read port
    hbs_ram u_ram00 (.clk(clk), .re(en), .we(we), .waddr(waddr),
                     .wdata(dv_item.value), .raddr(ra00), .rdata(h00));
    hbs_ram u_ram10 (.clk(clk), .re(en), .we(we), .waddr(waddr),
                     .wdata(dv_item.value), .raddr(ra10), .rdata(h10));
    hbs_ram u_ram01 (.clk(clk), .re(en), .we(we), .waddr(waddr),
                     .wdata(dv_item.value), .raddr(ra01), .rdata(h01));
    hbs_ram u_ram11 (.clk(clk), .re(en), .we(we), .waddr(waddr),
                     .wdata(dv_item.value), .raddr(ra11), .rdata(h11));

    // Read stage sideband; drop write beats here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mem_vld_reg <= 1'b0;
        else if (en)
            mem_vld_reg <= mem_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mem_out_reg <= dv_item.outside;
            mem_fx_reg  <= dv_qx[FRAC_W-1:0];
            mem_fz_reg  <= dv_qz[FRAC_W-1:0];
        end
    end

    hbs_lerp u_lerp (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (mem_vld_reg),
        .in_outside (mem_out_reg),
        .fx         (mem_fx_reg),
        .fz         (mem_fz_reg),
        .h00        (h00),
        .h10        (h10),
        .h01        (h01),
        .h11        (h11),
        .actor_y    (cfg_reg.actor_y),
        .out_vld    (out_valid),
        .height     (height),
        .outside    (outside)
    );

endmodule
